@@ hw/rtl/kct_pkg.sv @@
// Shared types, constants and the base decoder for the k-mer count table.
package kct_pkg;

    // Default sizing of the count table.
    localparam int MAX_K_DEF      = 10;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed interface widths.
    localparam int NUM_BASES = 10;
    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 4;
    localparam int COUNT_W   = 32;

    localparam logic [CFG_W-1:0] KMER_LEN_RESET = 4'd10;

    // Command and status codes.
    localparam logic CMD_ADD       = 1'b0;
    localparam logic CMD_QUERY     = 1'b1;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD    = 1'b1;

    // Base characters in upper case; setting bit 5 gives the lower-case form.
    localparam logic [CHAR_W-1:0] CHAR_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C   = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G   = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T   = 8'h54;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic       bad;
        logic [1:0] code;
    } t_base_dec;

    // Maps one character to its two-bit code, flagging anything that is not a base.
    function automatic t_base_dec base_decode(input logic [CHAR_W-1:0] ch);
        t_base_dec d;
        d.bad  = 1'b0;
        d.code = 2'd0;
        if (ch == CHAR_A || ch == (CHAR_A | CASE_BIT)) begin
            d.code = 2'd0;
        end else if (ch == CHAR_C || ch == (CHAR_C | CASE_BIT)) begin
            d.code = 2'd1;
        end else if (ch == CHAR_G || ch == (CHAR_G | CASE_BIT)) begin
            d.code = 2'd2;
        end else if (ch == CHAR_T || ch == (CHAR_T | CASE_BIT)) begin
            d.code = 2'd3;
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/kmer_count_table.sv @@
// K-mer count table: decodes base words into an index and counts them in a RAM.
//
// Usage. An input word (i_cmd plus ten ASCII base characters) is accepted at a
// rising edge where start is high and busy is low. The leading bases, as many as
// the programmed k-mer length, are decoded case-insensitively (A=0, C=1, G=2, T=3)
// and packed left to right into the counter address. An add bumps the saturating
// counter there; a query returns it. Any other character among those bases marks
// the word invalid: the table is left alone and o_status reports it.
// Each accepted word yields exactly one result word on o_status and o_count,
// shown for one cycle with o_valid. An accept registers the update state, which
// in turn registers the strobe; a new word may be accepted at the edge where the
// result is taken, and busy holds off any word while one is in flight.
// The accepting cycle issues the registered read of the counter RAM and the update
// cycle writes back the new count. The receiver cannot stall, and none is needed.
// The user must write the k-mer length through i_cfg_we / i_cfg_wdata only while
// the block is idle; the block does not enforce this. After reset the block sweeps
// all 4**MAX_K counter RAM entries (1048576 at the default size) to zero, one entry
// per cycle, with busy high; configuration writes are still taken during that sweep.
module kmer_count_table #(
    parameter int MAX_K      = kct_pkg::MAX_K_DEF,
    parameter int COUNT_BITS = kct_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_0,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_1,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_2,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_3,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_4,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_5,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_6,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_7,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_8,
    input  logic [kct_pkg::CHAR_W-1:0]  i_base_9,
    input  logic                        i_cfg_we,
    input  logic [kct_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                        o_valid,
    output logic                        o_status,
    output logic [kct_pkg::COUNT_W-1:0] o_count
);

    // Bases that can take part: bounded by both the table size and the ports.
    localparam int KEFF  = (MAX_K < kct_pkg::NUM_BASES) ? MAX_K : kct_pkg::NUM_BASES;
    localparam int IDX_W = 2 * MAX_K;
    localparam int PK_W  = 2 * KEFF;
    localparam int KW    = kct_pkg::CFG_W;

    logic [kct_pkg::CHAR_W-1:0] w_base [kct_pkg::NUM_BASES];
    kct_pkg::t_base_dec         w_dec  [KEFF];

    logic [KW-1:0]         w_k;
    logic [KW-1:0]         w_drop;
    logic [PK_W-1:0]       w_packed;
    logic [PK_W-1:0]       w_shifted;
    logic [IDX_W-1:0]      w_index;
    logic                  w_bad;

    kct_pkg::t_state       r_state, n_state;
    logic [IDX_W-1:0]      r_clr_addr;
    logic [KW-1:0]         r_k_cfg;
    logic                  r_out_valid, n_out_valid;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_cmd;
    logic                  r_bad;
    logic                  r_status, n_status;
    logic [kct_pkg::COUNT_W-1:0] r_count, n_count;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  accept;

    assign w_base[0] = i_base_0;
    assign w_base[1] = i_base_1;
    assign w_base[2] = i_base_2;
    assign w_base[3] = i_base_3;
    assign w_base[4] = i_base_4;
    assign w_base[5] = i_base_5;
    assign w_base[6] = i_base_6;
    assign w_base[7] = i_base_7;
    assign w_base[8] = i_base_8;
    assign w_base[9] = i_base_9;

    // Effective k-mer length: zero counts as one, anything too long is clamped.
    always_comb begin
        if (r_k_cfg == '0) begin
            w_k = KW'(1);
        end else if (r_k_cfg > KW'(KEFF)) begin
            w_k = KW'(KEFF);
        end else begin
            w_k = r_k_cfg;
        end
    end

    // Every base position decodes in parallel. The packed word holds all of
    // them with the first base on top; shifting right by the unused positions
    // leaves exactly the first k codes in the low bits.
    always_comb begin
        w_bad    = 1'b0;
        w_packed = '0;
        for (int i = 0; i < KEFF; i++) begin
            w_dec[i] = kct_pkg::base_decode(w_base[i]);
            w_packed[PK_W-1-2*i -: 2] = w_dec[i].code;
            if (KW'(i) < w_k) begin
                w_bad = w_bad | w_dec[i].bad;
            end
        end
    end

    assign w_drop    = KW'(KEFF) - w_k;
    assign w_shifted = w_packed >> {w_drop, 1'b0};
    assign w_index   = IDX_W'(w_shifted);

    assign busy   = (r_state != kct_pkg::ST_IDLE);
    assign accept = start && !busy;

    kct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (2 ** IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (w_index),
        .o_rdata (ram_rdata)
    );

    // Next state, RAM control and result formation. The read is issued in the
    // accepting cycle and the write-back follows in the update cycle; only one
    // word is in flight, so a read never overlaps a pending write.
    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_count     = r_count;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = ram_rdata + COUNT_BITS'(1);
        ram_re      = 1'b0;
        case (r_state)
            kct_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == '1) begin
                    n_state = kct_pkg::ST_IDLE;
                end
            end
            kct_pkg::ST_IDLE: begin
                if (start) begin
                    ram_re  = 1'b1;
                    n_state = kct_pkg::ST_UPDATE;
                end
            end
            kct_pkg::ST_UPDATE: begin
                n_out_valid = 1'b1;
                n_status    = r_bad ? kct_pkg::STATUS_BAD : kct_pkg::STATUS_OK;
                n_count     = '0;
                if (!r_bad) begin
                    if (r_cmd == kct_pkg::CMD_QUERY) begin
                        n_count = kct_pkg::COUNT_W'(ram_rdata);
                    end else if (ram_rdata != '1) begin
                        ram_we = 1'b1;
                    end
                end
                n_state = kct_pkg::ST_IDLE;
            end
            default: begin
                n_state = kct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kct_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_k_cfg     <= kct_pkg::KMER_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == kct_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cfg_we) begin
                r_k_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= w_index;
            r_cmd  <= i_cmd;
            r_bad  <= w_bad;
        end
        r_status <= n_status;
        r_count  <= n_count;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_count  = r_count;

endmodule

@@ hw/rtl/kct_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module kct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/kct_checker.sv @@
// Port-level checker for the k-mer count table, bound to the top level.
module kct_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_cmd,
    input logic                        o_valid,
    input logic                        o_status,
    input logic [kct_pkg::COUNT_W-1:0] o_count
);

    // Every accepted word produces a result on o_valid.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) ##1 i_rst_n |=> o_valid)
        else $error("accepted word produced no result");

    // No result appears without a matching accepted word.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, 2))
        else $error("result without an accepted word");

    // Only one word is in flight: the block is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("second word accepted while one is in flight");

    // Invalid k-mers always report a zero count.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == kct_pkg::STATUS_BAD) |-> (o_count == '0))
        else $error("invalid k-mer reported a nonzero count");

    // An add reports a zero count.
    a_add_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_cmd, 2) == kct_pkg::CMD_ADD) |-> (o_count == '0))
        else $error("add reported a nonzero count");

endmodule

bind kmer_count_table kct_checker u_kct_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_count  (o_count)
);
